// ===== hdl/sob_pkg.sv =====
// ----------------------------------------------------------------------------
// sob_pkg
// Types and constants shared by the source-over blend pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package sob_pkg;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 13;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SURFACE_WIDTH  = 1'b0,
    REG_SURFACE_HEIGHT = 1'b1
  } sob_reg_t;

  localparam logic [CFG_DAT_W-1:0] SURF_W_RESET = 13'd640;
  localparam logic [CFG_DAT_W-1:0] SURF_H_RESET = 13'd480;

  // Arithmetic widths
  localparam int unsigned NUM_W  = 24;  // weighted channel sum plus rounding
  localparam int unsigned COMB_W = 16;  // combined alpha, at most 255*255
  localparam int unsigned LANES  = 3;   // R, G, B

  localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;
  localparam logic [7:0] ALPHA_CLEAR  = 8'h00;

  // Per-pixel sideband that rides alongside the arithmetic
  typedef struct packed {
    logic        we;      // pixel will be stored
    logic        opaque;  // source replaces destination
    logic [31:0] src;     // source pixel for the opaque case
    logic [7:0]  alpha;   // output alpha of the blend case
    logic [11:0] x;
    logic [11:0] y;
  } sob_side_t;

  // Divider state for the three colour lanes
  typedef struct packed {
    logic [LANES-1:0][NUM_W-1:0] rem;
    logic [LANES-1:0][7:0]       quo;
    logic [COMB_W-1:0]           comb;
  } sob_div_t;

endpackage

`default_nettype wire

// ===== hdl/sob_prep.sv =====
// ----------------------------------------------------------------------------
// sob_prep
// First two pipeline stages: bounds check, alpha products, combined alpha,
// channel numerators and rounded output alpha.
// ----------------------------------------------------------------------------
`default_nettype none

module sob_prep
  import sob_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 valid_in,
  input  wire logic [31:0]          src_pixel,
  input  wire logic [31:0]          dst_pixel,
  input  wire logic [11:0]          pos_x,
  input  wire logic [11:0]          pos_y,
  input  wire logic [CFG_DAT_W-1:0] surface_width,
  input  wire logic [CFG_DAT_W-1:0] surface_height,
  output logic                      valid_out,
  output sob_side_t                 side_out,
  output sob_div_t                  div_out
);

  // Stage 1 registers
  logic                          s1_valid_r;
  sob_side_t                     s1_side_r,  s1_side_nxt;
  logic [LANES-1:0][15:0]        s1_csa_r,   s1_csa_nxt;
  logic [LANES-1:0][15:0]        s1_cdd_r,   s1_cdd_nxt;
  logic [7:0]                    s1_inv_r,   s1_inv_nxt;
  logic [COMB_W-1:0]             s1_comb_r,  s1_comb_nxt;

  // Stage 2 registers
  logic                          s2_valid_r;
  sob_side_t                     s2_side_r,  s2_side_nxt;
  sob_div_t                      s2_div_r,   s2_div_nxt;

  // Stage 1: bounds check and the 8x8 products
  always_comb begin
    logic [7:0]  sa;
    logic [7:0]  da;
    logic [15:0] sa_ext;
    logic        x_ok;
    logic        y_ok;
    sa     = src_pixel[31:24];
    da     = dst_pixel[31:24];
    sa_ext = {8'd0, sa};
    x_ok   = ({1'b0, pos_x} < surface_width) && ({20'd0, pos_x} < 32'(MAX_DIMENSION));
    y_ok   = ({1'b0, pos_y} < surface_height) && ({20'd0, pos_y} < 32'(MAX_DIMENSION));

    s1_side_nxt.we     = (sa != ALPHA_CLEAR) && x_ok && y_ok;
    s1_side_nxt.opaque = (sa == ALPHA_OPAQUE);
    s1_side_nxt.src    = src_pixel;
    s1_side_nxt.alpha  = ALPHA_CLEAR;
    s1_side_nxt.x      = pos_x;
    s1_side_nxt.y      = pos_y;

    s1_inv_nxt  = ALPHA_OPAQUE - sa;
    // sa*255 as a shift and subtract, plus da*(255-sa)
    s1_comb_nxt = ((sa_ext << 8) - sa_ext) + (da * s1_inv_nxt);

    for (int l = 0; l < LANES; l++) begin
      s1_csa_nxt[l] = src_pixel[8*l +: 8] * sa;
      s1_cdd_nxt[l] = dst_pixel[8*l +: 8] * da;
    end
  end

  // Stage 2: channel numerators and rounded alpha
  always_comb begin
    logic [16:0] a_sum;
    logic [8:0]  a_q0;
    logic [9:0]  a_rem;
    logic [8:0]  a_q;
    logic [NUM_W-1:0] csa_w;
    logic [NUM_W-1:0] cdd_w;
    logic [NUM_W-1:0] inv_w;
    a_sum = {1'b0, s1_comb_r} + 17'd127;
    // divide by 255: x/256 guess, remainder stays below 510
    a_q0  = a_sum[16:8];
    a_rem = {2'b00, a_sum[7:0]} + {1'b0, a_q0};
    a_q   = a_q0 + {8'd0, (a_rem >= 10'd255)};

    s2_side_nxt       = s1_side_r;
    s2_side_nxt.alpha = a_q[7:0];

    s2_div_nxt.comb = s1_comb_r;
    inv_w = {16'd0, s1_inv_r};
    for (int l = 0; l < LANES; l++) begin
      csa_w = {8'd0, s1_csa_r[l]};
      cdd_w = {8'd0, s1_cdd_r[l]};
      s2_div_nxt.rem[l] = ((csa_w << 8) - csa_w)
                        + (cdd_w * inv_w)
                        + NUM_W'(s1_comb_r >> 1);
      s2_div_nxt.quo[l] = 8'd0;
    end
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      s2_valid_r <= 1'b0;
    end else if (en) begin
      s1_valid_r <= valid_in;
      s2_valid_r <= s1_valid_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      s1_side_r <= s1_side_nxt;
      s1_csa_r  <= s1_csa_nxt;
      s1_cdd_r  <= s1_cdd_nxt;
      s1_inv_r  <= s1_inv_nxt;
      s1_comb_r <= s1_comb_nxt;
      s2_side_r <= s2_side_nxt;
      s2_div_r  <= s2_div_nxt;
    end
  end

  assign valid_out = s2_valid_r;
  assign side_out  = s2_side_r;
  assign div_out   = s2_div_r;

endmodule

`default_nettype wire

// ===== hdl/sob_div_stage.sv =====
// ----------------------------------------------------------------------------
// sob_div_stage
// One registered divider stage: two restoring quotient bits per colour lane.
// ----------------------------------------------------------------------------
`default_nettype none

module sob_div_stage
  import sob_pkg::*;
#(
  parameter int unsigned HI_BIT = 7
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic en,
  input  wire logic valid_in,
  input  sob_side_t side_in,
  input  sob_div_t  div_in,
  output logic      valid_out,
  output sob_side_t side_out,
  output sob_div_t  div_out
);

  logic      valid_r;
  sob_side_t side_r;
  sob_div_t  div_r, div_nxt;

  // Resolve quotient bits HI_BIT and HI_BIT-1
  always_comb begin
    logic [NUM_W-1:0] r;
    logic [NUM_W-1:0] d_hi;
    logic [NUM_W-1:0] d_lo;
    logic [7:0]       q;
    d_hi    = {{(NUM_W-COMB_W){1'b0}}, div_in.comb} << HI_BIT;
    d_lo    = {{(NUM_W-COMB_W){1'b0}}, div_in.comb} << (HI_BIT - 1);
    div_nxt = div_in;
    for (int l = 0; l < LANES; l++) begin
      r = div_in.rem[l];
      q = div_in.quo[l];
      if (r >= d_hi) begin
        r         = r - d_hi;
        q[HI_BIT] = 1'b1;
      end
      if (r >= d_lo) begin
        r             = r - d_lo;
        q[HI_BIT - 1] = 1'b1;
      end
      div_nxt.rem[l] = r;
      div_nxt.quo[l] = q;
    end
  end

  // Advance valid bit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_in;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    if (en) begin
      side_r <= side_in;
      div_r  <= div_nxt;
    end
  end

  assign valid_out = valid_r;
  assign side_out  = side_r;
  assign div_out   = div_r;

endmodule

`default_nettype wire

// ===== hdl/source_over_pixel_blend_top.sv =====
// Throughput: one pixel per clock; the 8-bit channel divide is split over
// four registered stages of two quotient bits each, so every stage takes a
// new pixel as it hands the last one on. An output stall freezes the whole
// pipeline.
// Reset: clears all valid bits; surface size returns to 640 x 480.
// ----------------------------------------------------------------------------
// source_over_pixel_blend_top
// Straight-alpha ARGB8888 source-over compositing pipeline with surface
// bounds check and a configuration write port.
// ----------------------------------------------------------------------------
`default_nettype none

module source_over_pixel_blend_top
  import sob_pkg::*;
#(
  parameter int unsigned MAX_DIMENSION = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // configuration writes
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [CFG_DAT_W-1:0] cfg_data,
  // input pixels
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [31:0]          in_src_pixel,
  input  wire logic [31:0]          in_dst_pixel,
  input  wire logic [11:0]          in_pos_x,
  input  wire logic [11:0]          in_pos_y,
  // results
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [31:0]               out_pixel,
  output logic [11:0]               out_write_x,
  output logic [11:0]               out_write_y,
  output logic                      out_write_enable
);

  localparam int unsigned DIV_STAGES = 4;

  logic [CFG_DAT_W-1:0] surf_w_r;
  logic [CFG_DAT_W-1:0] surf_h_r;
  logic                 en;

  logic      stg_valid [0:DIV_STAGES];
  sob_side_t stg_side  [0:DIV_STAGES];
  sob_div_t  stg_div   [0:DIV_STAGES];

  logic        out_valid_r;
  logic [31:0] out_pixel_r,  out_pixel_nxt;
  logic [11:0] out_x_r;
  logic [11:0] out_y_r;
  logic        out_we_r;

  // Configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      surf_w_r <= SURF_W_RESET;
      surf_h_r <= SURF_H_RESET;
    end else if (cfg_valid) begin
      unique case (sob_reg_t'(cfg_index))
        REG_SURFACE_WIDTH:  surf_w_r <= cfg_data;
        REG_SURFACE_HEIGHT: surf_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Hold every stage while a finished beat waits at the output
  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  sob_prep #(
    .MAX_DIMENSION(MAX_DIMENSION)
  ) u_prep (
    .clk           (clk),
    .rst_n         (rst_n),
    .en            (en),
    .valid_in      (in_valid),
    .src_pixel     (in_src_pixel),
    .dst_pixel     (in_dst_pixel),
    .pos_x         (in_pos_x),
    .pos_y         (in_pos_y),
    .surface_width (surf_w_r),
    .surface_height(surf_h_r),
    .valid_out     (stg_valid[0]),
    .side_out      (stg_side[0]),
    .div_out       (stg_div[0])
  );

  // Divider chain, most significant quotient bits first
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    sob_div_stage #(
      .HI_BIT(7 - 2 * g)
    ) u_div (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (en),
      .valid_in (stg_valid[g]),
      .side_in  (stg_side[g]),
      .div_in   (stg_div[g]),
      .valid_out(stg_valid[g+1]),
      .side_out (stg_side[g+1]),
      .div_out  (stg_div[g+1])
    );
  end

  // Select the stored colour
  always_comb begin
    sob_side_t s;
    s = stg_side[DIV_STAGES];
    if (!s.we) begin
      out_pixel_nxt = 32'd0;
    end else if (s.opaque) begin
      out_pixel_nxt = s.src;
    end else begin
      out_pixel_nxt = {s.alpha, stg_div[DIV_STAGES].quo[2],
                       stg_div[DIV_STAGES].quo[1], stg_div[DIV_STAGES].quo[0]};
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= stg_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_pixel_r <= out_pixel_nxt;
      out_x_r     <= stg_side[DIV_STAGES].x;
      out_y_r     <= stg_side[DIV_STAGES].y;
      out_we_r    <= stg_side[DIV_STAGES].we;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel        = out_pixel_r;
  assign out_write_x      = out_x_r;
  assign out_write_y      = out_y_r;
  assign out_write_enable = out_we_r;

  // A skipped pixel carries an all-zero colour
  a_skip_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_write_enable |-> out_pixel == 32'd0)
    else $error("skipped pixel with nonzero colour");

  // A stored pixel never has zero alpha
  a_store_alpha: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_enable |-> out_pixel[31:24] != ALPHA_CLEAR)
    else $error("stored pixel with zero alpha");

  // A frozen pipeline keeps its valid bits
  a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(stg_valid[0]) && $stable(stg_valid[DIV_STAGES])
            && $stable(out_valid_r))
    else $error("pipeline valid bits moved during stall");

endmodule

`default_nettype wire

// ===== sim/source_over_pixel_blend_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// source_over_pixel_blend_top_test
// Self-checking bench for the source-over blend pipeline. Pixels are pushed in
// random bursts against a randomly stalling result side. Each accepted pixel
// is run through a local straight-alpha compositor and the predicted write is
// compared field by field, in order, with the beat that comes back. The
// surface size is rewritten between phases, including zero and oversized
// values.
// ----------------------------------------------------------------------------

module source_over_pixel_blend_top_test;
  import sob_pkg::*;

  localparam int unsigned MAX_DIM     = 4096;
  localparam int unsigned LATENCY     = 7;
  localparam int unsigned IDLE_LIMIT  = 4000;
  localparam int unsigned HALF_PERIOD = 10;

  typedef enum int unsigned {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_t;

  // Predicted write for one pixel, and the compositor that produces it
  class blend_checker;
    typedef struct packed {
      logic [31:0] pixel;
      logic [11:0] x;
      logic [11:0] y;
      logic        we;
    } blend_write_t;

    blend_write_t         expected_writes[$];
    logic [CFG_DAT_W-1:0] surf_w;
    logic [CFG_DAT_W-1:0] surf_h;
    int unsigned          errors;

    function new();
      surf_w = SURF_W_RESET;
      surf_h = SURF_H_RESET;
      errors = 0;
    endfunction

    function void set_reg(sob_reg_t idx, logic [CFG_DAT_W-1:0] value);
      case (idx)
        REG_SURFACE_WIDTH:  surf_w = value;
        REG_SURFACE_HEIGHT: surf_h = value;
        default: ;
      endcase
    endfunction

    function int unsigned outstanding();
      return expected_writes.size();
    endfunction

    // Straight-alpha "over"; channels round half up, alpha rounds to nearest
    function logic [31:0] composite_over(logic [31:0] src, logic [31:0] dst);
      int unsigned sa, da, inv, comb, num;
      logic [31:0] res;
      sa   = src[31:24];
      da   = dst[31:24];
      inv  = 255 - sa;
      comb = sa * 255 + da * inv;
      if (comb == 0) return 32'h0;
      res = 32'h0;
      res[31:24] = 8'((comb + 127) / 255);
      for (int i = 0; i < 3; i++) begin
        num = src[8*i +: 8] * sa * 255 + dst[8*i +: 8] * da * inv + comb / 2;
        res[8*i +: 8] = 8'(num / comb);
      end
      return res;
    endfunction

    function void note_pixel(logic [31:0] src, logic [31:0] dst,
                             logic [11:0] x, logic [11:0] y);
      blend_write_t w;
      int unsigned lim_w, lim_h;
      lim_w = (surf_w > MAX_DIM) ? MAX_DIM : surf_w;
      lim_h = (surf_h > MAX_DIM) ? MAX_DIM : surf_h;
      w.x     = x;
      w.y     = y;
      w.we    = (src[31:24] != ALPHA_CLEAR) && (x < lim_w) && (y < lim_h);
      w.pixel = !w.we ? 32'h0 :
                (src[31:24] == ALPHA_OPAQUE) ? src : composite_over(src, dst);
      expected_writes.push_back(w);
    endfunction

    task report(string msg);
      $display("[%0t] mismatch: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic [31:0] pixel, logic [11:0] x, logic [11:0] y,
                      logic we);
      blend_write_t w;
      if (expected_writes.size() == 0) begin
        report($sformatf("unexpected beat pixel=%h at (%0d,%0d) we=%b",
                         pixel, x, y, we));
        return;
      end
      w = expected_writes.pop_front();
      if (pixel !== w.pixel)
        report($sformatf("pixel %h, want %h at (%0d,%0d)", pixel, w.pixel, w.x, w.y));
      if (x !== w.x)
        report($sformatf("write_x %0d, want %0d", x, w.x));
      if (y !== w.y)
        report($sformatf("write_y %0d, want %0d", y, w.y));
      if (we !== w.we)
        report($sformatf("write_enable %b, want %b at (%0d,%0d)", we, w.we, w.x, w.y));
    endtask
  endclass

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  sob_reg_t             cfg_index = REG_SURFACE_WIDTH;
  logic [CFG_DAT_W-1:0] cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [31:0]          in_src_pixel = '0;
  logic [31:0]          in_dst_pixel = '0;
  logic [11:0]          in_pos_x = '0;
  logic [11:0]          in_pos_y = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [31:0]          out_pixel;
  logic [11:0]          out_write_x;
  logic [11:0]          out_write_y;
  logic                 out_write_enable;

  blend_checker chk;
  int unsigned  burst_left = 0;
  int unsigned  idle_cycles = 0;
  stall_mode_t  stall_mode = STALL_NONE;
  int unsigned  stall_span = 0;

  source_over_pixel_blend_top #(
    .MAX_DIMENSION(MAX_DIM)
  ) uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_src_pixel     (in_src_pixel),
    .in_dst_pixel     (in_dst_pixel),
    .in_pos_x         (in_pos_x),
    .in_pos_y         (in_pos_y),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_pixel        (out_pixel),
    .out_write_x      (out_write_x),
    .out_write_y      (out_write_y),
    .out_write_enable (out_write_enable)
  );

  always begin
    clk = 1'b1;
    #HALF_PERIOD;
    clk = 1'b0;
    #HALF_PERIOD;
  end

  // Result-side backpressure: switch to a randomly chosen stall pattern whenever the current span runs out
  always @(negedge clk) begin
    if (stall_span == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_span <= $urandom_range(5, 80);
    end else begin
      stall_span <= stall_span - 1;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
      default:     out_stall <= (stall_span % 3 == 0);
    endcase
  end

  // Check every result beat taken
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      chk.check_result(out_pixel, out_write_x, out_write_y, out_write_enable);
  end

  // Abort when no beat moves on any channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("source_over_pixel_blend_top regression: fail");
      $finish;
    end
  end

  // Drop in_valid and idle the sender; n sets how long
  task automatic pause_input(int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  // Present one pixel beat and hold it until taken; gaps open between bursts
  task automatic send_pixel(logic [31:0] src, logic [31:0] dst,
                            logic [11:0] x, logic [11:0] y);
    if (burst_left == 0) begin
      pause_input($urandom_range(0, 12));
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(60, 200)
                                               : $urandom_range(1, 24);
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    in_src_pixel <= src;
    in_dst_pixel <= dst;
    in_pos_x     <= x;
    in_pos_y     <= y;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    chk.note_pixel(src, dst, x, y);
  endtask

  task automatic write_reg(sob_reg_t idx, logic [CFG_DAT_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    chk.set_reg(idx, value);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Hold the sender until every predicted write has come back, then let the pipe settle
  task automatic drain();
    pause_input(1);
    while (chk.outstanding() != 0) @(posedge clk);
    repeat (LATENCY + 3) @(posedge clk);
  endtask

  // Coordinate biased toward the inside and the edge of the surface
  function automatic logic [11:0] pick_coord(int unsigned size);
    int unsigned lim;
    int c;
    lim = (size > MAX_DIM) ? MAX_DIM : size;
    case ($urandom_range(0, 9))
      0, 1, 2: c = $urandom_range(0, 4095);
      3, 4, 5: c = int'(lim) - 2 + int'($urandom_range(0, 3));
      default: c = (lim == 0) ? 0 : int'($urandom_range(0, lim - 1));
    endcase
    if (c < 0) c = 0;
    if (c > 4095) c = 4095;
    return c[11:0];
  endfunction

  task automatic random_pixel(int unsigned w, int unsigned h);
    logic [31:0] src, dst;
    src = $urandom;
    dst = $urandom;
    case ($urandom_range(0, 9))
      0: src[31:24] = ALPHA_CLEAR;
      1: src[31:24] = ALPHA_OPAQUE;
      2: src[31:24] = $urandom_range(0, 1) ? 8'h01 : 8'hFE;
      default: ;
    endcase
    case ($urandom_range(0, 5))
      0: dst[31:24] = ALPHA_CLEAR;
      1: dst[31:24] = ALPHA_OPAQUE;
      default: ;
    endcase
    send_pixel(src, dst, pick_coord(w), pick_coord(h));
  endtask

  task automatic run_phase(int unsigned w, int unsigned h, int unsigned count);
    drain();
    write_reg(REG_SURFACE_WIDTH, w[CFG_DAT_W-1:0]);
    write_reg(REG_SURFACE_HEIGHT, h[CFG_DAT_W-1:0]);
    repeat (count) random_pixel(w, h);
  endtask

  initial begin
    chk = new();
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed beats against the reset surface of 640 x 480
    send_pixel(32'h00FFFFFF, 32'hFFFFFFFF, 12'd0, 12'd0);      // transparent source
    send_pixel(32'hFFFFFFFF, 32'h00000000, 12'd0, 12'd0);      // opaque source
    send_pixel(32'hFF123456, 32'h80ABCDEF, 12'd639, 12'd479);  // last pixel inside
    send_pixel(32'hFF123456, 32'h80ABCDEF, 12'd640, 12'd0);    // one column past
    send_pixel(32'hFF123456, 32'h80ABCDEF, 12'd0, 12'd480);    // one row past
    send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 12'd4095, 12'd4095);
    send_pixel(32'hFFFFFFFF, 32'hFFFFFFFF, 12'd4095, 12'd0);
    send_pixel(32'h00000000, 32'h00000000, 12'd1, 12'd1);
    send_pixel(32'h01FFFFFF, 32'h00000000, 12'd10, 12'd10);    // faint source, empty dest
    send_pixel(32'h01000000, 32'hFFFFFFFF, 12'd11, 12'd10);
    send_pixel(32'h01000000, 32'h01FFFFFF, 12'd12, 12'd10);
    send_pixel(32'hFE00FF80, 32'hFF80FF00, 12'd13, 12'd10);
    send_pixel(32'hFEFFFFFF, 32'hFE000000, 12'd14, 12'd10);
    send_pixel(32'h80FFFFFF, 32'h80000000, 12'd15, 12'd10);
    send_pixel(32'h80000000, 32'h00FFFFFF, 12'd16, 12'd10);
    send_pixel(32'h7F102030, 32'h01A0B0C0, 12'd17, 12'd10);
    send_pixel(32'h55AA55AA, 32'hAA55AA55, 12'd100, 12'd200);
    send_pixel(32'hAA55AA55, 32'h55AA55AA, 12'd639, 12'd0);

    // Surface settings, extremes first
    run_phase(1, 1, 100);
    run_phase(4096, 4096, 200);
    run_phase(0, 480, 80);
    run_phase(300, 0, 80);
    run_phase(8191, 4097, 150);
    run_phase(640, 480, 150);
    run_phase($urandom_range(1, 64), $urandom_range(1, 64), 200);
    run_phase($urandom_range(1, 4096), $urandom_range(1, 4096), 200);
    run_phase($urandom_range(0, 8191), $urandom_range(0, 8191), 200);
    run_phase($urandom_range(1, 200), $urandom_range(2000, 4096), 200);

    drain();
    if (chk.errors == 0) begin
      $display("source_over_pixel_blend_top regression: pass");
    end else begin
      $display("source_over_pixel_blend_top regression: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/sob_pkg.sv
hdl/sob_prep.sv
hdl/sob_div_stage.sv
hdl/source_over_pixel_blend_top.sv
sim/source_over_pixel_blend_top_test.sv
